/* design/hsv2rgb_pkg.sv */
// Shared constants, types and the helper function of the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  // Channel width: saturation, brightness and every color channel.
  localparam int unsigned COLOR_BITS  = 8;
  localparam int unsigned HUE_BITS    = 11;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned SECTOR_BITS = HUE_BITS - FRAC_BITS;
  localparam int unsigned TERM_BITS   = COLOR_BITS + FRAC_BITS;
  localparam int unsigned PROD_BITS   = COLOR_BITS + TERM_BITS;
  localparam int unsigned DIV_BITS    = 2 * COLOR_BITS + 1;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

  // Full scale of a channel, and full scale of a channel times one sector.
  localparam logic [COLOR_BITS-1:0] CHAN_MAX   = '1;
  localparam logic [TERM_BITS-1:0]  FULL_SCALE = {CHAN_MAX, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0]    FRAC_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

  // Channel ordering chosen by the front end; grey bypasses all products.
  typedef enum logic [2:0] {
    ORD_VTP,
    ORD_QVP,
    ORD_PVT,
    ORD_PQV,
    ORD_TPV,
    ORD_VPQ,
    ORD_GREY
  } order_e;

  typedef struct packed {
    logic [HUE_BITS-1:0]   hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS-1:0] brightness;
  } hsv_pixel_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } rgb_pixel_t;

  // Classified pixel handed from the front end to the back end.
  typedef struct packed {
    order_e                order;
    logic [COLOR_BITS-1:0] value;
    logic [COLOR_BITS-1:0] inv_sat;
    logic [TERM_BITS-1:0]  q_term;
    logic [TERM_BITS-1:0]  t_term;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Floor division by CHAN_MAX (2^COLOR_BITS - 1) for dividends up to CHAN_MAX squared.
  function automatic logic [COLOR_BITS-1:0] div_chan_max(input logic [2*COLOR_BITS-1:0] x);
    logic [DIV_BITS-1:0] sum;
    sum = DIV_BITS'(x) + DIV_BITS'(x >> COLOR_BITS) + DIV_BITS'(1);
    return sum[2*COLOR_BITS-1:COLOR_BITS];
  endfunction

endpackage

/* design/hsv_to_rgb_converter_top.sv */
// Top level of the HSV to RGB pixel converter.
`timescale 1ns / 1ps

// Converts one pixel given as hue, saturation and brightness into red, green
// and blue intensities. Hue runs from 0 to 1535 with 256 counts per sixty
// degree sector; saturation and brightness use all ones as full scale.
// Zero saturation gives a grey pixel equal to the brightness.
//
// Input side: the producer drives hsv_i and raises push; an item is taken at
// a clock edge where push is high and full is low.
// Result side: while empty is low the oldest result sits on rgb_o; it is
// taken at a clock edge where pop is high and empty is low.
//
// Throughput is one item per clock while the receiver keeps pop high. From
// the edge that accepts an item to the edge after which its result shows on
// rgb_o, the item passes the classifying front register, the queue, and the
// product register of the back end, whose scaling logic feeds the output
// register. When the receiver stalls, the back end holds, the queue fills, and
// full rises once the queue and the front register are both occupied; nothing
// is dropped. Reset clears every valid flag and queue pointer at once, so empty
// is high and full is low right after reset; no clearing pass is needed.
module hsv_to_rgb_converter_top
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  hsv_pixel_t hsv_i,
  output logic       empty,
  input  logic       pop,
  output rgb_pixel_t rgb_o
);

  logic          work_valid;
  work_t         work;
  work_t         queue_data;
  queue_status_t queue_status;
  logic          back_ready;
  logic          result_valid;

  hsv2rgb_front u_front (
    .clk_i,
    .rst_ni,
    .push_i         (push),
    .hsv_i,
    .full_o         (full),
    .queue_status_i (queue_status),
    .work_valid_o   (work_valid),
    .work_o         (work)
  );

  // The front register drains into the queue whenever the queue has room.
  hsv2rgb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .wr_en_i   (work_valid),
    .wr_data_i (work),
    .rd_en_i   (back_ready),
    .rd_data_o (queue_data),
    .status_o  (queue_status)
  );

  hsv2rgb_back u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i     (!queue_status.empty),
    .in_ready_o     (back_ready),
    .work_i         (queue_data),
    .result_valid_o (result_valid),
    .rgb_o,
    .pop_i          (pop)
  );

  assign empty = !result_valid;

endmodule

/* design/hsv2rgb_front.sv */
// Front end: accepts pixels, classifies the channel ordering and forms the blend terms.
`timescale 1ns / 1ps

module hsv2rgb_front
  import hsv2rgb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hsv_pixel_t    hsv_i,
  output logic          full_o,
  input  queue_status_t queue_status_i,
  output logic          work_valid_o,
  output work_t         work_o
);

  logic                   valid_q, valid_d;
  work_t                  work_q, work_d;
  logic                   accept;
  logic                   moved;
  logic [SECTOR_BITS-1:0] sector;
  logic [FRAC_BITS-1:0]   frac;
  logic [FRAC_BITS:0]     frac_comp;
  logic [TERM_BITS-1:0]   sf_prod;
  logic [TERM_BITS:0]     sfc_prod;
  logic [TERM_BITS:0]     t_full;

  assign moved  = valid_q && !queue_status_i.full;
  assign full_o = valid_q && queue_status_i.full;
  assign accept = push_i && !full_o;

  assign sector    = hsv_i.hue[HUE_BITS-1:FRAC_BITS];
  assign frac      = hsv_i.hue[FRAC_BITS-1:0];
  assign frac_comp = FRAC_ONE - {1'b0, frac};
  assign sf_prod   = TERM_BITS'(hsv_i.saturation) * TERM_BITS'(frac);
  assign sfc_prod  = (TERM_BITS+1)'(hsv_i.saturation) * (TERM_BITS+1)'(frac_comp);
  assign t_full    = {1'b0, FULL_SCALE} - sfc_prod;

  always_comb begin
    work_d.value   = hsv_i.brightness;
    work_d.inv_sat = CHAN_MAX - hsv_i.saturation;
    work_d.q_term  = FULL_SCALE - sf_prod;
    work_d.t_term  = t_full[TERM_BITS-1:0];
    if (hsv_i.saturation == '0) begin
      work_d.order = ORD_GREY;
    end else begin
      // Sectors past the last one reuse its ordering.
      unique case (sector)
        SECTOR_BITS'(0): work_d.order = ORD_VTP;
        SECTOR_BITS'(1): work_d.order = ORD_QVP;
        SECTOR_BITS'(2): work_d.order = ORD_PVT;
        SECTOR_BITS'(3): work_d.order = ORD_PQV;
        SECTOR_BITS'(4): work_d.order = ORD_TPV;
        default:         work_d.order = ORD_VPQ;
      endcase
    end
  end

  assign valid_d = accept || (valid_q && !moved);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      work_q <= work_d;
    end
  end

  assign work_valid_o = valid_q;
  assign work_o       = work_q;

endmodule

/* design/hsv2rgb_queue.sv */
// Short first-in first-out queue between the front end and the back end.
`timescale 1ns / 1ps

module hsv2rgb_queue
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  work_t         wr_data_i,
  input  logic          rd_en_i,
  output work_t         rd_data_o,
  output queue_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_wr = wr_en_i && !status_o.full;
  assign do_rd = rd_en_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem[rd_ptr_q];

endmodule

/* design/hsv2rgb_back.sv */
// Back end: multiplies, divides by full scale, orders the channels and holds the result.
`timescale 1ns / 1ps

module hsv2rgb_back
  import hsv2rgb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  work_t      work_i,
  output logic       result_valid_o,
  output rgb_pixel_t rgb_o,
  input  logic       pop_i
);

  typedef struct packed {
    order_e                  order;
    logic [COLOR_BITS-1:0]   value;
    logic [2*COLOR_BITS-1:0] prod_p;
    logic [PROD_BITS-1:0]    prod_q;
    logic [PROD_BITS-1:0]    prod_t;
  } prod_t;

  logic                  prod_valid_q;
  prod_t                 prod_q, prod_d;
  logic                  out_valid_q, out_valid_d;
  rgb_pixel_t            out_q, out_d;
  logic                  adv_out, adv_prod;
  logic [COLOR_BITS-1:0] lvl_p, lvl_q, lvl_t, lvl_v;

  assign adv_out    = !out_valid_q || pop_i;
  assign adv_prod   = !prod_valid_q || adv_out;
  assign in_ready_o = adv_prod;

  // Product stage.
  always_comb begin
    prod_d.order  = work_i.order;
    prod_d.value  = work_i.value;
    prod_d.prod_p = (2*COLOR_BITS)'(work_i.value) * (2*COLOR_BITS)'(work_i.inv_sat);
    prod_d.prod_q = PROD_BITS'(work_i.value) * PROD_BITS'(work_i.q_term);
    prod_d.prod_t = PROD_BITS'(work_i.value) * PROD_BITS'(work_i.t_term);
  end

  // Scaling and channel ordering stage.
  assign lvl_v = prod_q.value;
  assign lvl_p = div_chan_max(prod_q.prod_p);
  assign lvl_q = div_chan_max(prod_q.prod_q[PROD_BITS-1:FRAC_BITS]);
  assign lvl_t = div_chan_max(prod_q.prod_t[PROD_BITS-1:FRAC_BITS]);

  always_comb begin
    unique case (prod_q.order)
      ORD_VTP:  out_d = '{red: lvl_v, green: lvl_t, blue: lvl_p};
      ORD_QVP:  out_d = '{red: lvl_q, green: lvl_v, blue: lvl_p};
      ORD_PVT:  out_d = '{red: lvl_p, green: lvl_v, blue: lvl_t};
      ORD_PQV:  out_d = '{red: lvl_p, green: lvl_q, blue: lvl_v};
      ORD_TPV:  out_d = '{red: lvl_t, green: lvl_p, blue: lvl_v};
      ORD_VPQ:  out_d = '{red: lvl_v, green: lvl_p, blue: lvl_q};
      default:  out_d = '{red: lvl_v, green: lvl_v, blue: lvl_v};
    endcase
  end

  assign out_valid_d = adv_out ? prod_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (adv_prod) begin
        prod_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_prod && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (adv_out && prod_valid_q) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign rgb_o          = out_q;

endmodule

/* design/hsv2rgb_checker.sv */
// Port-level checks for the HSV to RGB converter and their binding to the top level.
`timescale 1ns / 1ps

module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input hsv_pixel_t hsv_i,
  input logic       empty,
  input logic       pop,
  input rgb_pixel_t rgb_o
);

  // One edge into reset, no result is shown and items are not refused.
  assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("converter not idle after a reset edge");

  // A waiting result that is not taken stays on the ports unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rgb_o)))
    else $error("stalled result changed or vanished");

  // The converter only starts refusing items right after one was pushed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push))
    else $error("full rose without a preceding push");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_checker (.*);

/* tb/sv/hsv_to_rgb_converter_top_tb.sv */
// Self-checking testbench of the HSV to RGB pixel converter.
`timescale 1ns / 1ps

// Each accepted pixel is converted by a fixed-point predictor kept in this
// file, and the expected color is queued. A receiver process pops results
// under random stalls and compares every channel with the oldest expected
// color. Stimulus runs as a short directed sweep of sector borders and
// corner values, then random pixels in three idling phases. A long output
// stall fills the block until it raises full, and a drain pause lets the
// pipeline run dry before more pixels follow.
module hsv_to_rgb_converter_top_tb;
  import hsv2rgb_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SECTOR_COUNT = 6;
  localparam int unsigned TAIL_CYCLES  = 10;
  localparam int unsigned LONG_STALL   = 120;

  // One pixel in flight: what was sent and the color it must come back as.
  typedef struct {
    hsv_pixel_t hsv;
    rgb_pixel_t rgb;
  } pending_color_t;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push   = 1'b0;
  logic       pop    = 1'b0;
  hsv_pixel_t hsv_i  = '0;
  logic       full;
  logic       empty;
  rgb_pixel_t rgb_o;

  pending_color_t pending_colors[$];

  int unsigned error_count     = 0;
  int unsigned pixels_sent     = 0;
  int unsigned colors_checked  = 0;
  int unsigned full_stalls     = 0;
  int unsigned cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned stall_request   = 0;
  int unsigned stall_left      = 0;

  hsv_to_rgb_converter_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .hsv_i  (hsv_i),
    .empty  (empty),
    .pop    (pop),
    .rgb_o  (rgb_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a run that stalls forever ends here as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d colors still outstanding",
               cycle_count, pending_colors.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Fixed-point HSV to RGB conversion. The hue splits into a sector (upper
  // bits) and a fraction of that sector (low byte). The helper levels p, q
  // and t are each floored once from the exact product, and the sector then
  // chooses which of them lands on which channel. Sectors six and seven,
  // which only a hue above 1535 reaches, reuse the ordering of sector five.
  function automatic rgb_pixel_t convert_hsv_pixel(input hsv_pixel_t px);
    int unsigned chan_full;
    int unsigned span;
    int unsigned sat;
    int unsigned val;
    int unsigned frac;
    int unsigned sector;
    int unsigned p_lvl;
    int unsigned q_lvl;
    int unsigned t_lvl;
    order_e      order;
    rgb_pixel_t  rgb;
    chan_full = (1 << COLOR_BITS) - 1;
    span      = chan_full << FRAC_BITS;
    sat       = px.saturation;
    val       = px.brightness;
    frac      = px.hue[FRAC_BITS-1:0];
    sector    = px.hue[HUE_BITS-1:FRAC_BITS];
    p_lvl     = (val * (chan_full - sat)) / chan_full;
    q_lvl     = (val * (span - sat * frac)) / span;
    t_lvl     = (val * (span - sat * ((1 << FRAC_BITS) - frac))) / span;
    if (sat == 0) begin
      order = ORD_GREY;
    end else if (sector >= SECTOR_COUNT) begin
      order = ORD_VPQ;
    end else begin
      order = order_e'(sector);
    end
    case (order)
      ORD_VTP: begin
        rgb = '{red: COLOR_BITS'(val), green: COLOR_BITS'(t_lvl), blue: COLOR_BITS'(p_lvl)};
      end
      ORD_QVP: begin
        rgb = '{red: COLOR_BITS'(q_lvl), green: COLOR_BITS'(val), blue: COLOR_BITS'(p_lvl)};
      end
      ORD_PVT: begin
        rgb = '{red: COLOR_BITS'(p_lvl), green: COLOR_BITS'(val), blue: COLOR_BITS'(t_lvl)};
      end
      ORD_PQV: begin
        rgb = '{red: COLOR_BITS'(p_lvl), green: COLOR_BITS'(q_lvl), blue: COLOR_BITS'(val)};
      end
      ORD_TPV: begin
        rgb = '{red: COLOR_BITS'(t_lvl), green: COLOR_BITS'(p_lvl), blue: COLOR_BITS'(val)};
      end
      ORD_VPQ: begin
        rgb = '{red: COLOR_BITS'(val), green: COLOR_BITS'(p_lvl), blue: COLOR_BITS'(q_lvl)};
      end
      default: begin
        rgb = '{red: COLOR_BITS'(val), green: COLOR_BITS'(val), blue: COLOR_BITS'(val)};
      end
    endcase
    return rgb;
  endfunction

  function automatic hsv_pixel_t make_pixel(input int unsigned h, input int unsigned s,
                                            input int unsigned v);
    hsv_pixel_t px;
    px.hue        = HUE_BITS'(h);
    px.saturation = COLOR_BITS'(s);
    px.brightness = COLOR_BITS'(v);
    return px;
  endfunction

  // Random pixel: mostly legal hues, a few out-of-range hues, and extra
  // weight on sector borders and on the extremes of saturation and value.
  function automatic hsv_pixel_t random_pixel();
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned pick;
    pick = $urandom_range(99);
    h = (pick < 6) ? $urandom_range(2047, 1536) : $urandom_range(1535, 0);
    pick = $urandom_range(99);
    if (pick < 8) begin
      h = h & ~32'hff;
    end else if (pick < 16) begin
      h = h | 32'hff;
    end
    pick = $urandom_range(99);
    s = (pick < 10) ? 0 : (pick < 20) ? 255 : $urandom_range(255);
    pick = $urandom_range(99);
    v = (pick < 10) ? 0 : (pick < 20) ? 255 : $urandom_range(255);
    return make_pixel(h, s, v);
  endfunction

  function automatic void check_channel(input string name, input hsv_pixel_t src,
                                        input logic [COLOR_BITS-1:0] want,
                                        input logic [COLOR_BITS-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch for hue %0d sat %0d val %0d: expected %0d, got %0d",
               $time, name, src.hue, src.saturation, src.brightness, want, got);
    end
  endfunction

  // Offers one pixel and returns at the edge that accepts it. Push stays high
  // afterwards so that back-to-back items need no gap; idling lowers it.
  task automatic send_pixel(input hsv_pixel_t px);
    pending_color_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      push  <= 1'b0;
      hsv_i <= hsv_pixel_t'($urandom);
      @(posedge clk_i);
    end
    push  <= 1'b1;
    hsv_i <= px;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    entry.hsv = px;
    entry.rgb = convert_hsv_pixel(px);
    pending_colors.push_back(entry);
    pixels_sent++;
  endtask

  // Lowers push and waits until every expected color has come out.
  task automatic wait_until_converted();
    push <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_colors.size() != 0);
  endtask

  // Receiver: checks each popped color and drives pop for the next edge.
  // A stall request from a test turns into a long hold counted down here.
  always @(posedge clk_i) begin
    pending_color_t head;
    if (rst_ni && pop && !empty) begin
      if (pending_colors.size() == 0) begin
        error_count++;
        $display("%0t: color %0h popped with no pixel outstanding", $time, rgb_o);
      end else begin
        head = pending_colors.pop_front();
        check_channel("red",   head.hsv, head.rgb.red,   rgb_o.red);
        check_channel("green", head.hsv, head.rgb.green, rgb_o.green);
        check_channel("blue",  head.hsv, head.rgb.blue,  rgb_o.blue);
        colors_checked++;
      end
    end
    if (stall_request > 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sector borders at fraction zero and full, both out-of-range sectors,
  // grey pixels, and the extremes of saturation and value.
  task automatic test_directed_corners();
    send_pixel(make_pixel(0,    255, 255));
    send_pixel(make_pixel(255,  255, 255));
    send_pixel(make_pixel(256,  255, 255));
    send_pixel(make_pixel(511,  255, 255));
    send_pixel(make_pixel(512,  255, 255));
    send_pixel(make_pixel(767,  255, 255));
    send_pixel(make_pixel(768,  255, 255));
    send_pixel(make_pixel(1023, 255, 255));
    send_pixel(make_pixel(1024, 255, 255));
    send_pixel(make_pixel(1279, 255, 255));
    send_pixel(make_pixel(1280, 255, 255));
    send_pixel(make_pixel(1535, 255, 255));
    send_pixel(make_pixel(1536, 200, 180));
    send_pixel(make_pixel(1791, 200, 180));
    send_pixel(make_pixel(1792, 255, 255));
    send_pixel(make_pixel(2047, 255, 255));
    send_pixel(make_pixel(700,  0,   200));
    send_pixel(make_pixel(2047, 0,   255));
    send_pixel(make_pixel(0,    0,   0));
    send_pixel(make_pixel(300,  255, 0));
    send_pixel(make_pixel(128,  1,   255));
    send_pixel(make_pixel(900,  255, 1));
    send_pixel(make_pixel(1400, 128, 128));
    send_pixel(make_pixel(640,  170, 85));
  endtask

  task automatic test_random_pixels(input int unsigned count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // The receiver holds off for a long stretch while pixels keep coming, so
  // the queue fills and full has to hold the sender back without a loss.
  task automatic test_output_backpressure();
    stall_request = LONG_STALL;
    repeat (40) send_pixel(random_pixel());
    wait_until_converted();
  endtask

  // The sender pauses until the pipeline is empty, then starts up again.
  task automatic test_pause_and_drain();
    repeat (12) send_pixel(random_pixel());
    wait_until_converted();
    repeat (12) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: the sender idles a third of the time, the receiver nearly half.
    send_idle_pct = 33;
    recv_idle_pct = 47;
    test_directed_corners();
    test_random_pixels(230);
    test_output_backpressure();

    // Phase two: the idling rates swap sides.
    send_idle_pct = 47;
    recv_idle_pct = 33;
    test_random_pixels(230);
    test_pause_and_drain();

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_pixels(220);

    wait_until_converted();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d pixels, checked %0d colors over three idling phases",
             pixels_sent, colors_checked);
    $display("Input held off by full on %0d edges during output stalls", full_stalls);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
